[hdl/ramask_pkg.sv]
// Shared constants, types and helpers for the rounded alpha mask block.
package ramask_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int POS_W      = $clog2(MAX_DIM);
   localparam int DIM_W      = POS_W + 1;
   localparam int RAD_W      = POS_W;
   localparam int DIFF_W     = DIM_W + 1;
   localparam int SQ_W       = 2 * DIM_W;
   localparam int CHAN_W     = 8;
   localparam int DEPTH_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = DIM_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASK_MODE     = 3'd0,
      CSR_IMAGE_WIDTH   = 3'd1,
      CSR_IMAGE_HEIGHT  = 3'd2,
      CSR_CORNER_RADIUS = 3'd3,
      CSR_SOURCE_DEPTH  = 3'd4
   } csr_index_type;

   localparam logic MODE_CIRCLE  = 1'b0;
   localparam logic MODE_ROUNDED = 1'b1;

   localparam logic [DEPTH_W-1:0] DEPTH_GREY = 3'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_RGB  = 3'd3;
   localparam logic [DEPTH_W-1:0] DEPTH_RGBA = 3'd4;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

   localparam logic [DIM_W-1:0]   MAX_DIM_V    = DIM_W'(MAX_DIM);
   localparam logic [DIM_W-1:0]   RST_WIDTH    = DIM_W'(64);
   localparam logic [DIM_W-1:0]   RST_HEIGHT   = DIM_W'(64);
   localparam logic [DIM_W-1:0]   RST_CORNER   = DIM_W'(8);
   localparam logic [DEPTH_W-1:0] RST_DEPTH    = DEPTH_RGBA;
   localparam logic               RST_MODE     = MODE_ROUNDED;

   typedef struct packed {
      logic                mode;
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [RAD_W-1:0]    radius;
      logic [DEPTH_W-1:0]  depth;
   } cfg_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > MAX_DIM_V) begin
         r = MAX_DIM_V;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[hdl/rounded_alpha_mask.sv]
// Top level of the rounded alpha mask: pixel stream to RGBA with a shaped alpha mask.
//
// Source pixels enter in raster order on the req_ channel (chan0..chan3) and
// each yields one RGBA pixel on the rsp_ channel, with rsp_last_pixel high on
// the final pixel of an image. A transaction moves at a clock edge where valid
// is high and stall is low; the receiver drives stall.
// An accepted request passes the input register, then the result register, to rsp_.
// Throughput is one pixel per cycle while rsp_stall is low, set by one input
// register and one result register with the distance squares between them.
// When rsp_stall holds a result, one more request still enters the input
// register; req_stall rises only when both registers are full.
// The csr_ port writes mode, width, height, corner radius and depth; csr_ready
// is always high. Write it only while no transaction is in flight.
// Synchronous reset loads the default configuration (rounded rectangle,
// 64 x 64, corner radius 8, depth 4), empties both registers and sets the
// column and row counters to zero.
module rounded_alpha_mask
   import ramask_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAN_W-1:0]     req_chan0,
   input  logic [CHAN_W-1:0]     req_chan1,
   input  logic [CHAN_W-1:0]     req_chan2,
   input  logic [CHAN_W-1:0]     req_chan3,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAN_W-1:0]     rsp_out_red,
   output logic [CHAN_W-1:0]     rsp_out_green,
   output logic [CHAN_W-1:0]     rsp_out_blue,
   output logic [CHAN_W-1:0]     rsp_out_alpha,
   output logic                  rsp_last_pixel,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              last;
      logic              need_test;
      logic [DIM_W-1:0]  dist_x;
      logic [DIM_W-1:0]  dist_y;
      logic [RAD_W-1:0]  radius;
   } stage_type;

   cfg_type               cfg;

   logic                  s1_valid_ff, s1_valid_in;
   stage_type             s1_ff, s1_in;
   logic                  s2_valid_ff, s2_valid_in;
   logic [CHAN_W-1:0]     red_ff, red_in;
   logic [CHAN_W-1:0]     green_ff, green_in;
   logic [CHAN_W-1:0]     blue_ff, blue_in;
   logic [CHAN_W-1:0]     alpha_ff, alpha_in;
   logic                  last_ff, last_in;
   logic [POS_W-1:0]      column_ff, column_in;
   logic [POS_W-1:0]      row_ff, row_in;

   logic                  s2_load;
   logic                  req_take;
   logic                  in_mask;

   logic signed [DIFF_W-1:0] x_s, y_s, w_s, h_s, r_s;
   logic signed [DIFF_W-1:0] cx_s, cy_s, dx_s, dy_s;
   logic                  left, right, top, bottom;
   logic                  row_end, pix_last;

   ramask_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign s2_load   = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s2_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      x_s    = signed'({{(DIFF_W-POS_W){1'b0}}, column_ff});
      y_s    = signed'({{(DIFF_W-POS_W){1'b0}}, row_ff});
      w_s    = signed'({{(DIFF_W-DIM_W){1'b0}}, cfg.width});
      h_s    = signed'({{(DIFF_W-DIM_W){1'b0}}, cfg.height});
      r_s    = signed'({{(DIFF_W-RAD_W){1'b0}}, cfg.radius});
      left   = x_s < r_s;
      right  = x_s >= (w_s - r_s);
      top    = y_s < r_s;
      bottom = y_s >= (h_s - r_s);
      if (cfg.mode == MODE_CIRCLE) begin
         cx_s = r_s;
         cy_s = r_s;
      end else begin
         cx_s = left ? r_s : (w_s - r_s - DIFF_W'(1));
         cy_s = top ? r_s : (h_s - r_s - DIFF_W'(1));
      end
      dx_s = x_s - cx_s;
      dy_s = y_s - cy_s;

      row_end  = x_s >= (w_s - DIFF_W'(1));
      pix_last = row_end && (y_s >= (h_s - DIFF_W'(1)));

      s1_in.dist_x    = dx_s[DIFF_W-1] ? DIM_W'(-dx_s) : DIM_W'(dx_s);
      s1_in.dist_y    = dy_s[DIFF_W-1] ? DIM_W'(-dy_s) : DIM_W'(dy_s);
      s1_in.radius    = cfg.radius;
      s1_in.last      = pix_last;
      s1_in.need_test = (cfg.mode == MODE_CIRCLE) ||
                        ((left || right) && (top || bottom));

      if (cfg.depth >= DEPTH_RGB) begin
         s1_in.red   = req_chan0;
         s1_in.green = req_chan1;
         s1_in.blue  = req_chan2;
      end else if (cfg.depth == DEPTH_GREY) begin
         s1_in.red   = req_chan0;
         s1_in.green = req_chan0;
         s1_in.blue  = req_chan0;
      end else begin
         s1_in.red   = '0;
         s1_in.green = '0;
         s1_in.blue  = '0;
      end
      s1_in.alpha = (cfg.depth == DEPTH_RGBA) ? req_chan3 : ALPHA_OPAQUE;
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (req_take) begin
         if (row_end) begin
            column_in = '0;
            row_in    = pix_last ? '0 : row_ff + POS_W'(1);
         end else begin
            column_in = column_ff + POS_W'(1);
         end
      end
      s1_valid_in = (!s1_valid_ff || s2_load) ? req_valid : s1_valid_ff;
      s2_valid_in = (!s2_valid_ff || !rsp_stall) ? s1_valid_ff : s2_valid_ff;
   end

   ramask_dist u_dist (
      .need_test (s1_ff.need_test),
      .dist_x    (s1_ff.dist_x),
      .dist_y    (s1_ff.dist_y),
      .radius    (s1_ff.radius),
      .in_mask   (in_mask)
   );

   always_comb begin
      red_in   = s1_ff.red;
      green_in = s1_ff.green;
      blue_in  = s1_ff.blue;
      alpha_in = in_mask ? s1_ff.alpha : ALPHA_CLEAR;
      last_in  = s1_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         column_ff   <= '0;
         row_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
      if (s2_load) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid      = s2_valid_ff;
   assign rsp_out_red    = red_ff;
   assign rsp_out_green  = green_ff;
   assign rsp_out_blue   = blue_ff;
   assign rsp_out_alpha  = alpha_ff;
   assign rsp_last_pixel = last_ff;

`ifndef SYNTH
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_take && pix_last) |=> (column_ff == '0 && row_ff == '0))
      else $error("counters did not wrap after the last pixel");

   a_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && rsp_stall) |-> req_stall)
      else $error("request taken while both registers are full");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> rsp_valid)
      else $error("result register load lost");

   a_mask: assert property (@(posedge clock) disable iff (reset)
      (s2_load && !in_mask) |=> (rsp_out_alpha == ALPHA_CLEAR))
      else $error("alpha not cleared outside the mask");

   a_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !s1_valid_ff && column_ff == '0 && row_ff == '0))
      else $error("state not cleared by reset");
`endif

endmodule

[hdl/ramask_csr.sv]
// Configuration registers and derived geometry for the alpha mask.
module ramask_csr
   import ramask_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   logic                mode_ff,   mode_in;
   logic [DIM_W-1:0]    width_ff,  width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [DIM_W-1:0]    corner_ff, corner_in;
   logic [DEPTH_W-1:0]  depth_ff,  depth_in;

   logic [DIM_W-1:0]    w_clamp;
   logic [DIM_W-1:0]    h_clamp;
   logic [DIM_W-1:0]    side_min;
   logic [DIM_W-1:0]    corner_lim;
   logic [DIM_W-1:0]    corner_use;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      corner_in = corner_ff;
      depth_in  = depth_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MASK_MODE:     mode_in   = csr_data[0];
            CSR_IMAGE_WIDTH:   width_in  = csr_data;
            CSR_IMAGE_HEIGHT:  height_in = csr_data;
            CSR_CORNER_RADIUS: corner_in = csr_data;
            CSR_SOURCE_DEPTH:  depth_in  = csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= RST_MODE;
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         corner_ff <= RST_CORNER;
         depth_ff  <= RST_DEPTH;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         corner_ff <= corner_in;
         depth_ff  <= depth_in;
      end
   end

   always_comb begin
      w_clamp    = clamp_dim(width_ff);
      h_clamp    = clamp_dim(height_ff);
      side_min   = (w_clamp < h_clamp) ? w_clamp : h_clamp;
      corner_lim = side_min >> 1;
      corner_use = (corner_ff > corner_lim) ? corner_lim : corner_ff;
      cfg.mode   = mode_ff;
      cfg.width  = w_clamp;
      cfg.depth  = depth_ff;
      if (mode_ff == MODE_CIRCLE) begin
         cfg.height = w_clamp;
         cfg.radius = w_clamp[DIM_W-1:1];
      end else begin
         cfg.height = h_clamp;
         cfg.radius = corner_use[RAD_W-1:0];
      end
   end

endmodule

[hdl/ramask_dist.sv]
// Squared-distance compare against the mask radius.
module ramask_dist
   import ramask_pkg::*;
(
   input  logic             need_test,
   input  logic [DIM_W-1:0] dist_x,
   input  logic [DIM_W-1:0] dist_y,
   input  logic [RAD_W-1:0] radius,
   output logic             in_mask
);

   logic [SQ_W-1:0]    x_sq;
   logic [SQ_W-1:0]    y_sq;
   logic [SQ_W:0]      dist_sq;
   logic [2*RAD_W-1:0] rad_sq;

   always_comb begin
      x_sq    = dist_x * dist_x;
      y_sq    = dist_y * dist_y;
      rad_sq  = radius * radius;
      dist_sq = {1'b0, x_sq} + {1'b0, y_sq};
      in_mask = !need_test || (dist_sq <= (SQ_W+1)'(rad_sq));
   end

endmodule
